[sv/isotp_rx_pkg.sv]
// Shared types and constants for the ISO-TP reassembly receiver.
package isotp_rx_pkg;

  // Kind of one result beat.
  typedef enum logic [1:0] {
    KindData = 2'd0,
    KindFc   = 2'd1,
    KindDone = 2'd2,
    KindErr  = 2'd3
  } kind_e;

  // Error causes reported with an error beat.
  localparam logic [1:0] CauseNotStart   = 2'd0;
  localparam logic [1:0] CauseNotConsec  = 2'd1;
  localparam logic [1:0] CauseTimeout    = 2'd2;
  localparam logic [1:0] CauseBadSingle  = 2'd3;
  localparam logic [1:0] CauseNone       = 2'd0;

  // Protocol control information type nibbles.
  localparam logic [3:0] PciSingle = 4'h0;
  localparam logic [3:0] PciFirst  = 4'h1;
  localparam logic [3:0] PciConsec = 4'h2;

  // Payload limits per frame type.
  localparam logic [11:0] FirstMaxBytes  = 12'd6;
  localparam logic [3:0]  SingleMaxLen   = 4'd7;
  localparam logic [11:0] ConsecMaxBytes = 12'd7;

  // Configuration register indexes and reset values.
  localparam int unsigned CfgIdxWidth  = 1;
  localparam int unsigned CfgDataWidth = 24;
  localparam logic [CfgIdxWidth-1:0] CfgFcId       = 1'd0;
  localparam logic [CfgIdxWidth-1:0] CfgWaitBudget = 1'd1;
  localparam logic [10:0] FcIdReset       = 11'd0;
  localparam logic [23:0] WaitBudgetReset = 24'd500000;

  // Default depth of the command queue between front and back.
  localparam int unsigned CmdQueueDepthDefault = 2;

  // One command from the front: some data bytes, then one closing beat.
  typedef struct packed {
    logic [2:0]  n_data;
    logic [55:0] bytes;
    logic [11:0] base_idx;
    kind_e       tail_kind;
    logic [11:0] tail_len;
    logic [1:0]  tail_cause;
  } cmd_t;

endpackage

[sv/isotp_rx_req_if.sv]
// Request channel: received CAN frames and time ticks.
interface isotp_rx_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [63:0] frame_bytes;

  modport source (output valid, output req_type, output frame_bytes, input ready);
  modport sink (input valid, input req_type, input frame_bytes, output ready);
endinterface

[sv/isotp_rx_res_if.sv]
// Result channel: reassembled bytes, flow-control requests, done and errors.
interface isotp_rx_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [11:0] byte_index;
  logic [11:0] msg_length;
  logic [10:0] fc_frame_id;
  logic [1:0]  error_cause;
  logic        last;

  modport source (output valid, output kind, output data_byte, output byte_index,
                  output msg_length, output fc_frame_id, output error_cause,
                  output last, input ready);
  modport sink (input valid, input kind, input data_byte, input byte_index,
                input msg_length, input fc_frame_id, input error_cause,
                input last, output ready);
endinterface

[sv/isotp_rx_front.sv]
// Front end: accepts frames and ticks, tracks the session and issues commands.
module isotp_rx_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  isotp_rx_req_if.sink        req_i,
  input  logic [23:0]         wait_budget_i,
  input  logic                q_full_i,
  output logic                push_o,
  output isotp_rx_pkg::cmd_t  cmd_o
);

  logic        busy_q, busy_d;
  logic [11:0] total_q, total_d;
  logic [11:0] rcvd_q, rcvd_d;
  logic [23:0] budget_q, budget_d;

  logic        accept;
  logic [7:0]  b0;
  logic [3:0]  pci;
  logic [11:0] first_tot;
  logic [11:0] rem;
  logic [2:0]  chunk;
  logic [11:0] rcvd_sum;

  assign req_i.ready = !q_full_i;
  assign accept      = req_i.valid && req_i.ready;
  assign b0          = req_i.frame_bytes[63:56];
  assign pci         = b0[7:4];
  assign first_tot   = {b0[3:0], req_i.frame_bytes[55:48]};
  assign rem         = (total_q > rcvd_q) ? (total_q - rcvd_q) : 12'd0;
  assign chunk       = (rem > isotp_rx_pkg::ConsecMaxBytes) ? 3'd7 : rem[2:0];
  assign rcvd_sum    = rcvd_q + {9'd0, chunk};

  // Classify the item against the session state and build its command.
  always_comb begin
    busy_d   = busy_q;
    total_d  = total_q;
    rcvd_d   = rcvd_q;
    budget_d = budget_q;
    push_o   = 1'b0;
    cmd_o.n_data     = 3'd0;
    cmd_o.bytes      = req_i.frame_bytes[55:0];
    cmd_o.base_idx   = 12'd0;
    cmd_o.tail_kind  = isotp_rx_pkg::KindErr;
    cmd_o.tail_len   = 12'd0;
    cmd_o.tail_cause = isotp_rx_pkg::CauseNone;
    if (accept) begin
      if (req_i.req_type) begin
        // Time tick: only counts while a multi-frame message is open.
        if (busy_q) begin
          if (budget_q == 24'd0) begin
            busy_d           = 1'b0;
            push_o           = 1'b1;
            cmd_o.tail_cause = isotp_rx_pkg::CauseTimeout;
          end else begin
            budget_d = budget_q - 24'd1;
          end
        end
      end else if (!busy_q) begin
        push_o = 1'b1;
        if (pci == isotp_rx_pkg::PciSingle) begin
          if (b0[3:0] > isotp_rx_pkg::SingleMaxLen) begin
            cmd_o.tail_cause = isotp_rx_pkg::CauseBadSingle;
          end else begin
            cmd_o.n_data    = b0[2:0];
            cmd_o.tail_kind = isotp_rx_pkg::KindDone;
            cmd_o.tail_len  = {8'd0, b0[3:0]};
          end
        end else if (pci == isotp_rx_pkg::PciFirst) begin
          cmd_o.bytes = {req_i.frame_bytes[47:0], 8'd0};
          if (first_tot <= isotp_rx_pkg::FirstMaxBytes) begin
            cmd_o.n_data    = first_tot[2:0];
            cmd_o.tail_kind = isotp_rx_pkg::KindDone;
            cmd_o.tail_len  = first_tot;
          end else begin
            cmd_o.n_data    = isotp_rx_pkg::FirstMaxBytes[2:0];
            cmd_o.tail_kind = isotp_rx_pkg::KindFc;
            busy_d          = 1'b1;
            total_d         = first_tot;
            rcvd_d          = isotp_rx_pkg::FirstMaxBytes;
            budget_d        = wait_budget_i;
          end
        end else begin
          cmd_o.tail_cause = isotp_rx_pkg::CauseNotStart;
        end
      end else begin
        push_o = 1'b1;
        if (pci != isotp_rx_pkg::PciConsec) begin
          busy_d           = 1'b0;
          cmd_o.tail_cause = isotp_rx_pkg::CauseNotConsec;
        end else begin
          cmd_o.n_data   = chunk;
          cmd_o.base_idx = rcvd_q;
          rcvd_d         = rcvd_sum;
          if (rcvd_sum >= total_q) begin
            busy_d          = 1'b0;
            cmd_o.tail_kind = isotp_rx_pkg::KindDone;
            cmd_o.tail_len  = total_q;
          end else begin
            cmd_o.tail_kind = isotp_rx_pkg::KindFc;
          end
        end
      end
    end
  end

  // Session state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      total_q  <= 12'd0;
      rcvd_q   <= 12'd0;
      budget_q <= 24'd0;
    end else begin
      busy_q   <= busy_d;
      total_q  <= total_d;
      rcvd_q   <= rcvd_d;
      budget_q <= budget_d;
    end
  end

endmodule

[sv/isotp_rx_fifo.sv]
// Short command queue between the front and back ends.
module isotp_rx_fifo #(
  parameter int unsigned Depth = isotp_rx_pkg::CmdQueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  isotp_rx_pkg::cmd_t cmd_i,
  output logic               full_o,
  output logic               valid_o,
  input  logic               pop_i,
  output isotp_rx_pkg::cmd_t cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  isotp_rx_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

[sv/isotp_rx_back.sv]
// Back end: plays out one command as data beats and a closing beat.
module isotp_rx_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  isotp_rx_pkg::cmd_t cmd_i,
  output logic               pop_o,
  input  logic [10:0]        fc_id_i,
  isotp_rx_res_if.source     res_o
);

  logic        active_q;
  logic [2:0]  rem_q;
  logic [55:0] bytes_q;
  logic [11:0] idx_q;
  isotp_rx_pkg::kind_e tail_kind_q;
  logic [11:0] tail_len_q;
  logic [1:0]  tail_cause_q;

  logic        out_valid_q;
  logic [1:0]  kind_q;
  logic [7:0]  data_q;
  logic [11:0] bidx_q;
  logic [11:0] len_q;
  logic [10:0] fcid_q;
  logic [1:0]  cause_q;
  logic        last_q;

  logic slot_free, emit, at_tail;

  assign slot_free = !out_valid_q || res_o.ready;
  assign emit      = active_q && slot_free;
  assign at_tail   = (rem_q == 3'd0);
  assign pop_o     = q_valid_i && (!active_q || (emit && at_tail));

  assign res_o.valid       = out_valid_q;
  assign res_o.kind        = kind_q;
  assign res_o.data_byte   = data_q;
  assign res_o.byte_index  = bidx_q;
  assign res_o.msg_length  = len_q;
  assign res_o.fc_frame_id = fcid_q;
  assign res_o.error_cause = cause_q;
  assign res_o.last        = last_q;

  // Command progress and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (slot_free) begin
        out_valid_q <= emit;
      end
      if (pop_o) begin
        active_q <= 1'b1;
      end else if (emit && at_tail) begin
        active_q <= 1'b0;
      end
    end
  end

  // Current command payload: shifts one byte per data beat.
  always_ff @(posedge clk_i) begin
    if (emit && !at_tail) begin
      rem_q   <= rem_q - 3'd1;
      bytes_q <= {bytes_q[47:0], 8'd0};
      idx_q   <= idx_q + 12'd1;
    end
    if (pop_o) begin
      rem_q        <= cmd_i.n_data;
      bytes_q      <= cmd_i.bytes;
      idx_q        <= cmd_i.base_idx;
      tail_kind_q  <= cmd_i.tail_kind;
      tail_len_q   <= cmd_i.tail_len;
      tail_cause_q <= cmd_i.tail_cause;
    end
  end

  // Output register: one result beat per cycle when the sink takes it.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (!at_tail) begin
        kind_q  <= isotp_rx_pkg::KindData;
        data_q  <= bytes_q[55:48];
        bidx_q  <= idx_q;
        len_q   <= 12'd0;
        fcid_q  <= 11'd0;
        cause_q <= isotp_rx_pkg::CauseNone;
        last_q  <= 1'b0;
      end else begin
        kind_q  <= tail_kind_q;
        data_q  <= 8'd0;
        bidx_q  <= 12'd0;
        len_q   <= tail_len_q;
        fcid_q  <= (tail_kind_q == isotp_rx_pkg::KindFc) ? fc_id_i : 11'd0;
        cause_q <= tail_cause_q;
        last_q  <= 1'b1;
      end
    end
  end

endmodule

[sv/isotp_reassembly_receiver.sv]
// Top level of the ISO-TP reassembly receiver.
//
// The req_i channel carries one beat per received CAN frame (req_type 0,
// eight bytes with byte 0 in the top bits) or per time tick (req_type 1).
// The res_o channel returns, per frame, the reassembled data bytes with
// their message index and then one closing beat: message done with the
// total length, a flow-control request on the configured identifier, or
// an error with its cause; a tick that times out a message gives an
// error beat. The closing beat carries last = 1. The configuration port
// writes fc_id (index 0) and wait_budget (index 1); the user must write
// it only while the block is idle; the block itself does not enforce
// this. The front end classifies each beat in the cycle it is accepted
// and queues a command; the back end plays each command out one result
// beat per cycle, while the sink takes them, into an output register.
// Requests keep flowing while the command queue has room, so a stalled
// result sink backs up into the queue and then into req_i.ready. Reset
// returns the session to idle, empties the queue and restores fc_id to
// 0 and wait_budget to 500000 ticks.
module isotp_reassembly_receiver #(
  parameter int unsigned CmdQueueDepth = isotp_rx_pkg::CmdQueueDepthDefault
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  isotp_rx_req_if.sink                           req_i,
  isotp_rx_res_if.source                         res_o,
  input  logic                                   cfg_we_i,
  input  logic [isotp_rx_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [isotp_rx_pkg::CfgDataWidth-1:0]  cfg_data_i
);

  logic [10:0]        fc_id_q;
  logic [23:0]        wait_budget_q;
  logic               push, q_full, q_valid, pop;
  isotp_rx_pkg::cmd_t cmd_in, cmd_out;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_id_q       <= isotp_rx_pkg::FcIdReset;
      wait_budget_q <= isotp_rx_pkg::WaitBudgetReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        isotp_rx_pkg::CfgFcId:       fc_id_q       <= cfg_data_i[10:0];
        isotp_rx_pkg::CfgWaitBudget: wait_budget_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  isotp_rx_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .wait_budget_i (wait_budget_q),
    .q_full_i      (q_full),
    .push_o        (push),
    .cmd_o         (cmd_in)
  );

  isotp_rx_fifo #(
    .Depth (CmdQueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .cmd_o   (cmd_out)
  );

  isotp_rx_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .cmd_i     (cmd_out),
    .pop_o     (pop),
    .fc_id_i   (fc_id_q),
    .res_o     (res_o)
  );

endmodule
